/* rtl/binary_min_heap_queue_defines.svh */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_defines
// Assertion macros for the heap queue; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked at every rising clock edge outside reset
`define BMHQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define BMHQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BMHQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BMHQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants and helpers for the binary min-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int unsigned DepthDef = 1024;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned StatW    = 2;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StEmpty = 2'd1;
  localparam logic [StatW-1:0] StFull  = 2'd2;

  localparam logic KindIns = 1'b0;
  localparam logic KindRem = 1'b1;

  // signed less-than on stored words
  function automatic logic key_lt(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

`default_nettype wire

/* rtl/bmhq_mem.sv */
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_mem import bmhq_pkg::*; #(
  parameter  int unsigned DEPTH = DepthDef,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire logic [KeyW-1:0] wdata_i,
  input  wire logic [AW-1:0]   raddr_a_i,
  input  wire logic [AW-1:0]   raddr_b_i,
  output logic      [KeyW-1:0] rdata_a_o,
  output logic      [KeyW-1:0] rdata_b_o
);

  logic [KeyW-1:0] mem_q [DEPTH];
  logic [KeyW-1:0] rda_q, rdb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rda_q <= mem_q[raddr_a_i];
    rdb_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rda_q;
  assign rdata_b_o = rdb_q;

endmodule

`default_nettype wire

/* rtl/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of signed keys held in a synchronous RAM.
// Errors and an insert into an empty heap go straight from IDLE to RESP;
// other words walk the heap level by level; each level costs one RAM read.
// One word at a time: a new word is taken the cycle after the result strobe.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
// Reset clears the entry count; RAM contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_min_heap_queue_defines.svh"

module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter  int unsigned DEPTH = DepthDef,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   kind_i,
  input  wire logic signed [KeyW-1:0] key_in_i,
  output logic                        done_o,
  output logic signed [KeyW-1:0]      key_out_o,
  output logic        [StatW-1:0]     status_o,
  output logic        [CW-1:0]        count_after_o,
  output logic                        is_empty_o
);

  localparam int unsigned IW = AW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_DNL  = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [KeyW-1:0]  kout_q, kout_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic             rvalid_q, rvalid_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_ra, mem_rb;
  logic [KeyW-1:0]  mem_wdata, mem_rda, mem_rdb;

  bmhq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_ra),
    .raddr_b_i (mem_rb),
    .rdata_a_o (mem_rda),
    .rdata_b_o (mem_rdb)
  );

  // sift-up indices
  logic [CW-1:0] cnt_m1, cnt_par;
  logic [AW-1:0] par, gpar;
  assign cnt_m1  = count_q - CW'(1);
  assign cnt_par = cnt_m1 >> 1;
  assign par     = (pos_q - AW'(1)) >> 1;
  assign gpar    = (par - AW'(1)) >> 1;

  // sift-down: pick among hole key and the two children just read
  logic [IW-1:0]   cnt_ext, cur_l, cur_r;
  logic            take_l, take_r, moved;
  logic [KeyW-1:0] bval_l, bval;
  logic [AW-1:0]   best_idx, dn_node;
  logic [IW-1:0]   nd_l, nd_r;
  logic            has_l, has_r;

  assign cnt_ext  = IW'(count_q);
  assign cur_l    = {1'b0, pos_q, 1'b1};
  assign cur_r    = cur_l + IW'(1);
  assign take_l   = key_lt(mem_rda, key_q);
  assign bval_l   = take_l ? mem_rda : key_q;
  assign take_r   = rvalid_q && key_lt(mem_rdb, bval_l);
  assign moved    = take_l || take_r;
  assign bval     = take_r ? mem_rdb : bval_l;
  assign best_idx = take_r ? cur_r[AW-1:0] : cur_l[AW-1:0];

  // children of the node the hole moves to next
  assign dn_node = (state_q == S_DNL) ? '0 : best_idx;
  assign nd_l    = {1'b0, dn_node, 1'b1};
  assign nd_r    = nd_l + IW'(1);
  assign has_l   = nd_l < cnt_ext;
  assign has_r   = nd_r < cnt_ext;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    key_d     = key_q;
    kout_d    = kout_q;
    stat_d    = stat_q;
    rvalid_d  = rvalid_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = key_q;
    mem_ra    = '0;
    mem_rb    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kout_d = '0;
          stat_d = StOk;
          if (kind_i == KindIns) begin
            if (count_q == CW'(DEPTH)) begin
              stat_d  = StFull;
              state_d = S_RESP;
            end else begin
              count_d = count_q + CW'(1);
              key_d   = key_in_i;
              pos_d   = count_q[AW-1:0];
              if (count_q == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = key_in_i;
                state_d   = S_RESP;
              end else begin
                mem_ra  = cnt_par[AW-1:0];
                state_d = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = StEmpty;
              state_d = S_RESP;
            end else begin
              // fetch root and last entry together
              mem_ra  = '0;
              mem_rb  = cnt_m1[AW-1:0];
              count_d = cnt_m1;
              pos_d   = '0;
              state_d = S_DNL;
            end
          end
        end
      end
      S_UP: begin
        mem_we = 1'b1;
        if (key_lt(key_q, mem_rda)) begin
          // parent moves down into the hole
          mem_wdata = mem_rda;
          pos_d     = par;
          if (par == '0) begin
            state_d = S_WR;
          end else begin
            mem_ra = gpar;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_WR: begin
        mem_we  = 1'b1;
        state_d = S_RESP;
      end
      S_DNL: begin
        kout_d = mem_rda;
        key_d  = mem_rdb;
        if (count_q == '0) begin
          state_d = S_RESP;
        end else if (!has_l) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = mem_rdb;
          state_d   = S_RESP;
        end else begin
          mem_ra   = nd_l[AW-1:0];
          mem_rb   = has_r ? nd_r[AW-1:0] : nd_l[AW-1:0];
          rvalid_d = has_r;
          state_d  = S_DN;
        end
      end
      S_DN: begin
        mem_we = 1'b1;
        if (!moved) begin
          state_d = S_RESP;
        end else begin
          // smaller child moves up into the hole
          mem_wdata = bval;
          pos_d     = best_idx;
          if (!has_l) begin
            state_d = S_WR;
          end else begin
            mem_ra   = nd_l[AW-1:0];
            mem_rb   = has_r ? nd_r[AW-1:0] : nd_l[AW-1:0];
            rvalid_d = has_r;
          end
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    key_q    <= key_d;
    kout_q   <= kout_d;
    stat_q   <= stat_d;
    rvalid_q <= rvalid_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_RESP);
  assign key_out_o     = kout_q;
  assign status_o      = stat_q;
  assign count_after_o = count_q;
  assign is_empty_o    = (count_q == '0);

  `BMHQ_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result strobe held")
  `BMHQ_ASSERT(a_take_busy, clk_i, rst_ni, (start && !busy) |=> busy, "word taken, not busy")
  `BMHQ_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CW'(DEPTH), "count beyond depth")
  `BMHQ_ASSERT_IMPL(a_empty_err, clk_i, rst_ni, done_o && status_o == StEmpty,
                    is_empty_o && key_out_o == '0, "bad empty result")
  `BMHQ_ASSERT_IMPL(a_dn_pos, clk_i, rst_ni, state_q == S_DN, CW'(pos_q) < count_q,
                    "hole beyond heap")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_min_heap_queue: a short table of directed
// words, then random inserts and removes that fill the heap to full, drain it
// below half and mix, each result checked against a shadow heap kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import bmhq_pkg::*;

  localparam int unsigned DEPTH     = DepthDef;
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int          RandItems = 1925;
  localparam int          StallMax  = 2000;

  localparam logic signed [KeyW-1:0] KeyMin = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic signed [KeyW-1:0] KeyMax = {1'b0, {(KeyW-1){1'b1}}};

  typedef struct {
    logic signed [KeyW-1:0] key_out;
    logic [StatW-1:0]       status;
    logic [CW-1:0]          count_after;
    logic                   is_empty;
  } heap_reply_t;

  typedef struct {
    logic                   op;
    logic signed [KeyW-1:0] key;
    bit                     typed;
    heap_reply_t            want;
  } stim_row_t;

  typedef enum logic [1:0] {PhFill, PhDrain, PhMix} phase_e;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   start    = 1'b0;
  logic                   kind_i   = KindIns;
  logic signed [KeyW-1:0] key_in_i = '0;
  logic                   busy;
  logic                   done_o;
  logic signed [KeyW-1:0] key_out_o;
  logic [StatW-1:0]       status_o;
  logic [CW-1:0]          count_after_o;
  logic                   is_empty_o;

  // shadow copy of the heap and the words still owed by the block
  logic signed [KeyW-1:0] shadow_heap [DEPTH];
  int unsigned            shadow_fill = 0;
  heap_reply_t            due_q [$];
  int                     fault_cnt   = 0;
  int                     idle_cycles = 0;

  binary_min_heap_queue #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .key_in_i      (key_in_i),
    .done_o        (done_o),
    .key_out_o     (key_out_o),
    .status_o      (status_o),
    .count_after_o (count_after_o),
    .is_empty_o    (is_empty_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // insert sifts up on a strictly larger parent; remove sifts down to the
  // strictly smaller child, left child on a tie
  function automatic heap_reply_t heap_apply(input logic op,
                                             input logic signed [KeyW-1:0] key);
    heap_reply_t            r;
    int unsigned            pos;
    int unsigned            up;
    int unsigned            lc;
    int unsigned            rc;
    int unsigned            best;
    logic signed [KeyW-1:0] tmp;
    r = '{'0, StOk, '0, 1'b0};
    if (op == KindIns) begin
      if (shadow_fill == DEPTH) begin
        r.status = StFull;
      end else begin
        pos = shadow_fill;
        shadow_heap[pos] = key;
        shadow_fill++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(shadow_heap[pos] < shadow_heap[up])) break;
          tmp = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[up];
          shadow_heap[up] = tmp;
          pos = up;
        end
      end
    end else if (shadow_fill == 0) begin
      r.status = StEmpty;
    end else begin
      r.key_out = shadow_heap[0];
      shadow_fill--;
      shadow_heap[0] = shadow_heap[shadow_fill];
      pos = 0;
      forever begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        if (lc < shadow_fill && shadow_heap[lc] < shadow_heap[best]) best = lc;
        if (rc < shadow_fill && shadow_heap[rc] < shadow_heap[best]) best = rc;
        if (best == pos) break;
        tmp = shadow_heap[pos];
        shadow_heap[pos] = shadow_heap[best];
        shadow_heap[best] = tmp;
        pos = best;
      end
    end
    r.count_after = CW'(shadow_fill);
    r.is_empty    = (shadow_fill == 0);
    return r;
  endfunction

  function automatic logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return KeyMin;
      1:       return KeyMax;
      2, 3, 4: return $signed($urandom_range(0, 8)) - 4;  // dense, lots of ties
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap(input bit calm);
    if (calm || $urandom_range(0, 99) >= 36) return 0;
    return $urandom_range(1, 5);
  endfunction

  // drive one word and hold it until the block takes it
  task automatic send_word(input logic op, input logic signed [KeyW-1:0] key,
                           input int gap, output heap_reply_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    kind_i   <= op;
    key_in_i <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = heap_apply(op, key);
  endtask

  // sender stands back until every owed word has come home
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
  endtask

  task automatic flag_field(input string field, input logic [KeyW-1:0] want,
                            input logic [KeyW-1:0] got);
    fault_cnt++;
    if (fault_cnt <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    heap_reply_t due;
    if (rst_ni && done_o) begin
      if (due_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10) $display("result word with nothing outstanding");
      end else begin
        due = due_q.pop_front();
        if (key_out_o !== due.key_out)
          flag_field("key_out", due.key_out, key_out_o);
        if (status_o !== due.status)
          flag_field("status", KeyW'(due.status), KeyW'(status_o));
        if (count_after_o !== due.count_after)
          flag_field("count_after", KeyW'(due.count_after), KeyW'(count_after_o));
        if (is_empty_o !== due.is_empty)
          flag_field("is_empty", KeyW'(due.is_empty), KeyW'(is_empty_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < StallMax) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t   plan [$];
    heap_reply_t want;
    heap_reply_t none;
    phase_e      phase;
    int          full_tries;
    logic        op;

    none = '{'0, StOk, '0, 1'b0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty and extremes first, then ties and a full sorted drain
    plan.push_back('{KindRem, 32'sh5a5a5a5a, 1'b1, '{'0, StEmpty, CW'(0), 1'b1}});
    plan.push_back('{KindIns, KeyMax, 1'b1, '{'0, StOk, CW'(1), 1'b0}});
    plan.push_back('{KindIns, KeyMin, 1'b1, '{'0, StOk, CW'(2), 1'b0}});
    plan.push_back('{KindRem, KeyMax, 1'b1, '{KeyMin, StOk, CW'(1), 1'b0}});
    plan.push_back('{KindRem, KeyMin, 1'b1, '{KeyMax, StOk, CW'(0), 1'b1}});
    plan.push_back('{KindRem, '0, 1'b1, '{'0, StEmpty, CW'(0), 1'b1}});
    plan.push_back('{KindIns, -1, 1'b1, '{'0, StOk, CW'(1), 1'b0}});
    plan.push_back('{KindIns, 0, 1'b0, none});
    plan.push_back('{KindIns, 1, 1'b0, none});
    plan.push_back('{KindIns, -1, 1'b0, none});
    plan.push_back('{KindIns, 0, 1'b0, none});
    plan.push_back('{KindIns, KeyMin, 1'b0, none});
    plan.push_back('{KindIns, KeyMax, 1'b0, none});
    plan.push_back('{KindIns, 5, 1'b0, none});
    plan.push_back('{KindIns, 3, 1'b0, none});
    repeat (9) plan.push_back('{KindRem, KeyMax, 1'b0, none});
    plan.push_back('{KindRem, KeyMin, 1'b1, '{'0, StEmpty, CW'(0), 1'b1}});

    foreach (plan[r]) begin
      send_word(plan[r].op, plan[r].key, pick_gap(1'b0), want);
      due_q.push_back(plan[r].typed ? plan[r].want : want);
    end
    settle();

    // fill to full and knock on it, drain below half, then mix freely
    phase      = PhFill;
    full_tries = 0;
    for (int n = 0; n < RandItems; n++) begin
      case (phase)
        PhFill:  op = (shadow_fill == DEPTH || $urandom_range(0, 99) < 96) ? KindIns
                                                                            : KindRem;
        PhDrain: op = ($urandom_range(0, 99) < 92) ? KindRem : KindIns;
        default: op = $urandom_range(0, 1) ? KindRem : KindIns;
      endcase
      send_word(op, pick_key(), pick_gap(n >= 300 && n < 650), want);
      due_q.push_back(want);
      if (phase == PhFill && want.status == StFull) begin
        full_tries++;
        if (full_tries >= 4) begin
          settle();
          phase = PhDrain;
        end
      end else if (phase == PhDrain && shadow_fill < DEPTH / 2) begin
        phase = PhMix;
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_mem.sv
rtl/binary_min_heap_queue.sv
verif/testbench.sv
